>>> src/ucc_pkg.sv
// Package for the update session command checker.
// Holds command and error codes, reset values, and the command and reply beat types.
// Used by ucc_front, ucc_queue, ucc_back and update_session_command_checker.
package ucc_pkg;

    // Command codes, also used as the reply kind.
    localparam logic [2:0] OP_HANDSHAKE = 3'd0;
    localparam logic [2:0] OP_HEADER    = 3'd1;
    localparam logic [2:0] OP_DATA      = 3'd2;
    localparam logic [2:0] OP_COMPLETE  = 3'd3;
    localparam logic [2:0] OP_INSTALL   = 3'd4;
    localparam logic [2:0] OP_ACTIVATE  = 3'd5;
    localparam logic [2:0] OP_QUERY_VER = 3'd6;
    localparam logic [2:0] OP_OTHER     = 3'd7;

    // Reply error codes.
    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_SEQUENCE = 3'd1;
    localparam logic [2:0] ERR_BEYOND   = 3'd2;
    localparam logic [2:0] ERR_VERIFY   = 3'd3;
    localparam logic [2:0] ERR_BUSY     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FREE_FLASH = 2'd0;
    localparam logic [1:0] CFG_MAX_PACKET = 2'd1;
    localparam logic [1:0] CFG_MTU        = 2'd2;

    localparam logic [31:0] FREE_FLASH_RESET = 32'd262144;
    localparam logic [15:0] MAX_PACKET_RESET = 16'd256;
    localparam logic [15:0] MTU_RESET        = 16'd512;

    localparam logic [7:0] VER_MAJOR_RESET = 8'd1;
    localparam logic [7:0] VER_MINOR_RESET = 8'd0;
    localparam logic [7:0] VER_PATCH_RESET = 8'd0;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [2:0]  op;
        logic        block_truncated;
        logic [7:0]  ver_major;
        logic [7:0]  ver_minor;
        logic [7:0]  ver_patch;
        logic [31:0] size_value;
        logic [31:0] block_offset;
        logic [15:0] block_length;
        logic [15:0] blk_tmo;
        logic [15:0] inst_tmo;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  reply_kind;
        logic [2:0]  status;
        logic [31:0] offset_value;
        logic [7:0]  rep_major;
        logic [7:0]  rep_minor;
        logic [7:0]  rep_patch;
        logic        estimate_seconds;
        logic [15:0] blk_tmo_out;
        logic [15:0] inst_tmo_out;
        logic [31:0] free_space;
        logic [15:0] packet_limit;
        logic [15:0] mtu_value;
    } t_reply;

endpackage

>>> src/ucc_front.sv
// Front stage: accepts command beats, drops those that give no reply, registers the rest.
// Depends on ucc_pkg.
module ucc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_payload_short,
    input  ucc_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output ucc_pkg::t_cmd  o_cmd
);

    logic          r_valid;
    ucc_pkg::t_cmd r_cmd;
    logic          n_valid;
    logic          w_accept;
    logic          w_keep;
    logic          w_fixed_part;

    // Handshake, data block and complete carry a fixed request part.
    assign w_fixed_part = (i_cmd.op == ucc_pkg::OP_HANDSHAKE) ||
                          (i_cmd.op == ucc_pkg::OP_DATA) ||
                          (i_cmd.op == ucc_pkg::OP_COMPLETE);
    assign w_keep   = (i_cmd.op != ucc_pkg::OP_OTHER) && !(i_payload_short && w_fixed_part);
    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = w_keep;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_keep) begin
            r_cmd <= i_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

>>> src/ucc_queue.sv
// Short command queue between the front and back stages.
// Depends on ucc_pkg.
module ucc_queue #(
    parameter int DEPTH = ucc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ucc_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output ucc_pkg::t_cmd  o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    ucc_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          w_push;
    logic          w_pop;

    assign o_ready = (r_count != FULL);
    assign o_valid = (r_count != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> src/ucc_back.sv
// Back stage: holds the session state and the configuration registers, carries out one
// command per cycle unless the reply stalls, and registers the reply beat. Depends on ucc_pkg.
module ucc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [1:0]      i_cfg_index,
    input  logic [31:0]     i_cfg_wdata,
    input  logic            i_valid,
    output logic            o_ready,
    input  ucc_pkg::t_cmd   i_cmd,
    output logic            o_valid,
    input  logic            i_ready,
    output ucc_pkg::t_reply o_reply
);

    logic [31:0] r_free_flash;
    logic [15:0] r_max_packet;
    logic [15:0] r_mtu;

    logic [7:0]  r_cur_major, r_cur_minor, r_cur_patch;
    logic [7:0]  r_tgt_major, r_tgt_minor, r_tgt_patch;
    logic [31:0] r_image_size;
    logic [31:0] r_bytes_rx;
    logic        r_hs_seen;
    logic        r_hdr_seen;
    logic        r_cmp_seen;

    logic [7:0]  n_cur_major, n_cur_minor, n_cur_patch;
    logic [7:0]  n_tgt_major, n_tgt_minor, n_tgt_patch;
    logic [31:0] n_image_size;
    logic [31:0] n_bytes_rx;
    logic        n_hs_seen;
    logic        n_hdr_seen;
    logic        n_cmp_seen;

    logic            r_out_valid;
    ucc_pkg::t_reply r_reply;
    ucc_pkg::t_reply n_reply;

    logic        w_take;
    logic [32:0] w_block_end;
    logic        w_seq_err;

    assign o_ready = !r_out_valid || i_ready;
    assign w_take  = i_valid && o_ready;

    // Block end is formed one bit wider so that it cannot wrap.
    assign w_block_end = {1'b0, i_cmd.block_offset} + {17'd0, i_cmd.block_length};
    assign w_seq_err   = !r_hdr_seen || !r_hs_seen || i_cmd.block_truncated ||
                         (i_cmd.block_offset != r_bytes_rx);

    always_comb begin
        n_cur_major  = r_cur_major;
        n_cur_minor  = r_cur_minor;
        n_cur_patch  = r_cur_patch;
        n_tgt_major  = r_tgt_major;
        n_tgt_minor  = r_tgt_minor;
        n_tgt_patch  = r_tgt_patch;
        n_image_size = r_image_size;
        n_bytes_rx   = r_bytes_rx;
        n_hs_seen    = r_hs_seen;
        n_hdr_seen   = r_hdr_seen;
        n_cmp_seen   = r_cmp_seen;
        n_reply            = '0;
        n_reply.reply_kind = i_cmd.op;
        n_reply.status     = ucc_pkg::ERR_OK;
        unique case (i_cmd.op)
            ucc_pkg::OP_HANDSHAKE: begin
                n_tgt_major  = i_cmd.ver_major;
                n_tgt_minor  = i_cmd.ver_minor;
                n_tgt_patch  = i_cmd.ver_patch;
                n_image_size = i_cmd.size_value;
                n_bytes_rx   = '0;
                n_hs_seen    = 1'b1;
                n_hdr_seen   = 1'b0;
                n_cmp_seen   = 1'b0;
                n_reply.blk_tmo_out  = i_cmd.blk_tmo;
                n_reply.inst_tmo_out = i_cmd.inst_tmo;
                n_reply.free_space   = r_free_flash;
                n_reply.packet_limit = r_max_packet;
                n_reply.mtu_value    = r_mtu;
            end
            ucc_pkg::OP_HEADER: begin
                if (!r_hs_seen) begin
                    n_reply.status = ucc_pkg::ERR_SEQUENCE;
                end else begin
                    n_hdr_seen = 1'b1;
                    n_cmp_seen = 1'b0;
                end
            end
            ucc_pkg::OP_DATA: begin
                if (w_seq_err) begin
                    n_reply.status = ucc_pkg::ERR_SEQUENCE;
                end else if (w_block_end > {1'b0, r_image_size}) begin
                    n_reply.status = ucc_pkg::ERR_BEYOND;
                end else begin
                    n_bytes_rx = w_block_end[31:0];
                end
                n_reply.offset_value = n_bytes_rx;
            end
            ucc_pkg::OP_COMPLETE: begin
                if (!r_hdr_seen || !r_hs_seen || (i_cmd.size_value != r_image_size) ||
                    (r_bytes_rx != r_image_size)) begin
                    n_reply.status = ucc_pkg::ERR_VERIFY;
                end else begin
                    n_cmp_seen = 1'b1;
                end
            end
            ucc_pkg::OP_INSTALL: begin
                if (!r_cmp_seen) begin
                    n_reply.status = ucc_pkg::ERR_BUSY;
                end else begin
                    n_reply.estimate_seconds = 1'b1;
                    n_cur_major = r_tgt_major;
                    n_cur_minor = r_tgt_minor;
                    n_cur_patch = r_tgt_patch;
                end
            end
            default: begin
                // Activate check and version query report the running version.
                n_reply.rep_major = r_cur_major;
                n_reply.rep_minor = r_cur_minor;
                n_reply.rep_patch = r_cur_patch;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_flash <= ucc_pkg::FREE_FLASH_RESET;
            r_max_packet <= ucc_pkg::MAX_PACKET_RESET;
            r_mtu        <= ucc_pkg::MTU_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ucc_pkg::CFG_FREE_FLASH: r_free_flash <= i_cfg_wdata;
                ucc_pkg::CFG_MAX_PACKET: r_max_packet <= i_cfg_wdata[15:0];
                ucc_pkg::CFG_MTU:        r_mtu        <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_major  <= ucc_pkg::VER_MAJOR_RESET;
            r_cur_minor  <= ucc_pkg::VER_MINOR_RESET;
            r_cur_patch  <= ucc_pkg::VER_PATCH_RESET;
            r_tgt_major  <= ucc_pkg::VER_MAJOR_RESET;
            r_tgt_minor  <= ucc_pkg::VER_MINOR_RESET;
            r_tgt_patch  <= ucc_pkg::VER_PATCH_RESET;
            r_image_size <= '0;
            r_bytes_rx   <= '0;
            r_hs_seen    <= 1'b0;
            r_hdr_seen   <= 1'b0;
            r_cmp_seen   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_take) begin
                r_cur_major  <= n_cur_major;
                r_cur_minor  <= n_cur_minor;
                r_cur_patch  <= n_cur_patch;
                r_tgt_major  <= n_tgt_major;
                r_tgt_minor  <= n_tgt_minor;
                r_tgt_patch  <= n_tgt_patch;
                r_image_size <= n_image_size;
                r_bytes_rx   <= n_bytes_rx;
                r_hs_seen    <= n_hs_seen;
                r_hdr_seen   <= n_hdr_seen;
                r_cmp_seen   <= n_cmp_seen;
            end
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_reply <= n_reply;
        end
    end

    assign o_valid = r_out_valid;
    assign o_reply = r_reply;

    // The session flags only ever advance in order: handshake, header, complete.
    a_hdr_needs_hs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_seen |-> r_hs_seen)
        else $error("header flag set without handshake");

    a_cmp_needs_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_seen |-> r_hdr_seen)
        else $error("complete flag set without header");

    a_rx_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_rx <= r_image_size)
        else $error("received count beyond image size");

    a_estimate_only_install: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_reply.estimate_seconds) |->
            (r_reply.reply_kind == ucc_pkg::OP_INSTALL &&
             r_reply.status == ucc_pkg::ERR_OK))
        else $error("install estimate on a reply that is not an accepted install");

endmodule

>>> src/update_session_command_checker.sv
// Top level of the update session command checker: front stage, command queue, back stage.
// Depends on ucc_pkg, ucc_front, ucc_queue and ucc_back.
//
//  Channel     Direction  Handshake                     Contents
//  s_axis      in         s_axis_tvalid/s_axis_tready   one decoded command beat
//  m_axis      out        m_axis_tvalid/m_axis_tready   one reply beat
//  cfg         in         i_cfg_wr_en                   register write, no read-back
//
// One command beat can be taken every cycle while the front has room, and the back stage
// executes one command per cycle while no reply waits on m_axis_tready. With no stall the
// front registers a command, the queue stores it and the back stage registers its reply.
// Beats with a short payload for a command that needs a fixed part, and other commands,
// give no reply and are dropped in the front stage. While m_axis_tready is low the front
// keeps taking beats until the reply register, the queue and the front register are full.
// Reset is synchronous, active low.
module update_session_command_checker #(
    parameter int QUEUE_DEPTH = ucc_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // payload_short, block_truncated, ver_major, ver_minor, ver_patch, size_value,
    // block_offset, block_length, host block timeout, host install timeout, zero pad
    input  logic [143:0] s_axis_tdata,
    // op
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, offset_value, rep_major, rep_minor, rep_patch, estimate_seconds,
    // echoed block timeout, echoed install timeout, free_space, packet_limit, mtu_value,
    // zero pad
    output logic [159:0] m_axis_tdata,
    // reply_kind
    output logic [2:0]   m_axis_tuser
);

    ucc_pkg::t_cmd   w_in_cmd;
    ucc_pkg::t_cmd   w_front_cmd;
    ucc_pkg::t_cmd   w_queue_cmd;
    ucc_pkg::t_reply w_reply;
    logic            w_front_valid;
    logic            w_front_ready;
    logic            w_queue_valid;
    logic            w_queue_ready;

    assign w_in_cmd.op              = s_axis_tuser;
    assign w_in_cmd.block_truncated = s_axis_tdata[1];
    assign w_in_cmd.ver_major       = s_axis_tdata[9:2];
    assign w_in_cmd.ver_minor       = s_axis_tdata[17:10];
    assign w_in_cmd.ver_patch       = s_axis_tdata[25:18];
    assign w_in_cmd.size_value      = s_axis_tdata[57:26];
    assign w_in_cmd.block_offset    = s_axis_tdata[89:58];
    assign w_in_cmd.block_length    = s_axis_tdata[105:90];
    assign w_in_cmd.blk_tmo         = s_axis_tdata[121:106];
    assign w_in_cmd.inst_tmo        = s_axis_tdata[137:122];

    ucc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_payload_short (s_axis_tdata[0]),
        .i_cmd           (w_in_cmd),
        .o_valid         (w_front_valid),
        .i_ready         (w_front_ready),
        .o_cmd           (w_front_cmd)
    );

    ucc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .i_cmd   (w_front_cmd),
        .o_valid (w_queue_valid),
        .i_ready (w_queue_ready),
        .o_cmd   (w_queue_cmd)
    );

    ucc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_queue_valid),
        .o_ready     (w_queue_ready),
        .i_cmd       (w_queue_cmd),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_reply     (w_reply)
    );

    assign m_axis_tuser          = w_reply.reply_kind;
    assign m_axis_tdata[2:0]     = w_reply.status;
    assign m_axis_tdata[34:3]    = w_reply.offset_value;
    assign m_axis_tdata[42:35]   = w_reply.rep_major;
    assign m_axis_tdata[50:43]   = w_reply.rep_minor;
    assign m_axis_tdata[58:51]   = w_reply.rep_patch;
    assign m_axis_tdata[59]      = w_reply.estimate_seconds;
    assign m_axis_tdata[75:60]   = w_reply.blk_tmo_out;
    assign m_axis_tdata[91:76]   = w_reply.inst_tmo_out;
    assign m_axis_tdata[123:92]  = w_reply.free_space;
    assign m_axis_tdata[139:124] = w_reply.packet_limit;
    assign m_axis_tdata[155:140] = w_reply.mtu_value;
    assign m_axis_tdata[159:156] = 4'd0;

endmodule

>>> bench/update_session_reply_checker.sv
// Watches the command, reply and register-write channels of update_session_command_checker,
// predicts every reply from the accepted command beats and compares them field by field.
// Depends on ucc_pkg for the command, error and register codes and for the reply type.
module update_session_reply_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [143:0] s_axis_tdata,
    input  logic [2:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [159:0] m_axis_tdata,
    input  logic [2:0]   m_axis_tuser,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Command beat layout, highest field first.
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] inst_tmo;
        logic [15:0] blk_tmo;
        logic [15:0] block_length;
        logic [31:0] block_offset;
        logic [31:0] size_value;
        logic [7:0]  ver_patch;
        logic [7:0]  ver_minor;
        logic [7:0]  ver_major;
        logic        block_truncated;
        logic        payload_short;
    } t_cmd_word;

    // Reply beat layout, highest field first.
    typedef struct packed {
        logic [3:0]  pad;
        logic [15:0] mtu_value;
        logic [15:0] packet_limit;
        logic [31:0] free_space;
        logic [15:0] inst_tmo_out;
        logic [15:0] blk_tmo_out;
        logic        estimate_seconds;
        logic [7:0]  rep_patch;
        logic [7:0]  rep_minor;
        logic [7:0]  rep_major;
        logic [31:0] offset_value;
        logic [2:0]  status;
    } t_reply_word;

    logic [31:0] cfg_free_flash;
    logic [15:0] cfg_max_packet;
    logic [15:0] cfg_mtu;

    logic [7:0]  installed_ver [3];
    logic [7:0]  staged_ver [3];
    logic [31:0] image_bytes;
    logic [31:0] received_bytes;
    logic        handshake_ok;
    logic        header_ok;
    logic        image_verified;

    ucc_pkg::t_reply awaited_replies [$];
    int              mismatch_total = 0;

    assign o_fail_count = mismatch_total;

    task automatic clear_session_state();
        cfg_free_flash   = ucc_pkg::FREE_FLASH_RESET;
        cfg_max_packet   = ucc_pkg::MAX_PACKET_RESET;
        cfg_mtu          = ucc_pkg::MTU_RESET;
        installed_ver[0] = ucc_pkg::VER_MAJOR_RESET;
        installed_ver[1] = ucc_pkg::VER_MINOR_RESET;
        installed_ver[2] = ucc_pkg::VER_PATCH_RESET;
        staged_ver       = installed_ver;
        image_bytes      = '0;
        received_bytes   = '0;
        handshake_ok     = 1'b0;
        header_ok        = 1'b0;
        image_verified   = 1'b0;
    endtask

    // Advances the session by one command and works out its reply, if it has one.
    task automatic predict_session_reply(input t_cmd_word c, input logic [2:0] op,
                                         output bit has_reply, output ucc_pkg::t_reply r);
        logic [32:0] block_end;
        has_reply = 1'b0;
        r = '0;
        if (op == ucc_pkg::OP_OTHER) return;
        if (c.payload_short && (op == ucc_pkg::OP_HANDSHAKE || op == ucc_pkg::OP_DATA ||
                                op == ucc_pkg::OP_COMPLETE)) return;
        has_reply = 1'b1;
        r.reply_kind = op;
        case (op)
            ucc_pkg::OP_HANDSHAKE: begin
                staged_ver[0]  = c.ver_major;
                staged_ver[1]  = c.ver_minor;
                staged_ver[2]  = c.ver_patch;
                image_bytes    = c.size_value;
                received_bytes = '0;
                handshake_ok   = 1'b1;
                header_ok      = 1'b0;
                image_verified = 1'b0;
                r.blk_tmo_out  = c.blk_tmo;
                r.inst_tmo_out = c.inst_tmo;
                r.free_space   = cfg_free_flash;
                r.packet_limit = cfg_max_packet;
                r.mtu_value    = cfg_mtu;
            end
            ucc_pkg::OP_HEADER: begin
                if (!handshake_ok) begin
                    r.status = ucc_pkg::ERR_SEQUENCE;
                end else begin
                    header_ok      = 1'b1;
                    image_verified = 1'b0;
                end
            end
            ucc_pkg::OP_DATA: begin
                // The end of the block is formed one bit wider so that it cannot wrap.
                block_end = {1'b0, c.block_offset} + {17'b0, c.block_length};
                if (!header_ok || !handshake_ok || c.block_truncated ||
                    c.block_offset != received_bytes) begin
                    r.status = ucc_pkg::ERR_SEQUENCE;
                end else if (block_end > {1'b0, image_bytes}) begin
                    r.status = ucc_pkg::ERR_BEYOND;
                end else begin
                    received_bytes = block_end[31:0];
                end
                r.offset_value = received_bytes;
            end
            ucc_pkg::OP_COMPLETE: begin
                if (!header_ok || !handshake_ok || c.size_value != image_bytes ||
                    received_bytes != image_bytes) begin
                    r.status = ucc_pkg::ERR_VERIFY;
                end else begin
                    image_verified = 1'b1;
                end
            end
            ucc_pkg::OP_INSTALL: begin
                if (!image_verified) begin
                    r.status = ucc_pkg::ERR_BUSY;
                end else begin
                    r.estimate_seconds = 1'b1;
                    installed_ver      = staged_ver;
                end
            end
            default: begin
                r.rep_major = installed_ver[0];
                r.rep_minor = installed_ver[1];
                r.rep_patch = installed_ver[2];
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want) begin
            $display("%0t: reply %s expected %0h, got %0h", $time, name, want, seen);
            mismatch_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        ucc_pkg::t_reply want;
        bit              has_reply;
        t_reply_word     rw;
        if (!i_rst_n) begin
            clear_session_state();
            awaited_replies.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    ucc_pkg::CFG_FREE_FLASH: cfg_free_flash = i_cfg_wdata;
                    ucc_pkg::CFG_MAX_PACKET: cfg_max_packet = i_cfg_wdata[15:0];
                    ucc_pkg::CFG_MTU:        cfg_mtu        = i_cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_session_reply(t_cmd_word'(s_axis_tdata), s_axis_tuser, has_reply,
                                      want);
                if (has_reply) awaited_replies.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                rw = m_axis_tdata;
                if (awaited_replies.size() == 0) begin
                    $display("%0t: unexpected reply kind %0h data %0h", $time,
                             m_axis_tuser, m_axis_tdata);
                    mismatch_total++;
                end else begin
                    want = awaited_replies.pop_front();
                    check_field("reply_kind", want.reply_kind, m_axis_tuser);
                    check_field("status", want.status, rw.status);
                    check_field("offset_value", want.offset_value, rw.offset_value);
                    check_field("rep_major", want.rep_major, rw.rep_major);
                    check_field("rep_minor", want.rep_minor, rw.rep_minor);
                    check_field("rep_patch", want.rep_patch, rw.rep_patch);
                    check_field("estimate_seconds", want.estimate_seconds,
                                rw.estimate_seconds);
                    check_field("blk_tmo_out", want.blk_tmo_out, rw.blk_tmo_out);
                    check_field("inst_tmo_out", want.inst_tmo_out, rw.inst_tmo_out);
                    check_field("free_space", want.free_space, rw.free_space);
                    check_field("packet_limit", want.packet_limit, rw.packet_limit);
                    check_field("mtu_value", want.mtu_value, rw.mtu_value);
                    check_field("pad", '0, rw.pad);
                end
            end
        end
        o_pending <= awaited_replies.size();
    end

endmodule

>>> bench/update_session_command_checker_tb.sv
// Testbench top for update_session_command_checker: clock, reset, register writes and
// command stimulus under several stall patterns; replies are judged by update_session_reply_checker.
// Depends on ucc_pkg, the block's RTL and bench/update_session_reply_checker.sv.
module update_session_command_checker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_GOAL    = 1850;
    localparam int DRAIN_CYCLES = 12;
    // An index past the last register; a write there must change nothing.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef struct {
        logic [2:0]  op;
        logic        payload_short;
        logic        block_truncated;
        logic [7:0]  ver_major;
        logic [7:0]  ver_minor;
        logic [7:0]  ver_patch;
        logic [31:0] size_value;
        logic [31:0] block_offset;
        logic [15:0] block_length;
        logic [15:0] blk_tmo;
        logic [15:0] inst_tmo;
    } t_update_cmd;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_wr_en   = 1'b0;
    logic [1:0]   i_cfg_index   = '0;
    logic [31:0]  i_cfg_wdata   = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata  = '0;
    logic [2:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [159:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    int          fail_count;
    int          pending_replies;
    int          items_counted = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    update_session_command_checker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    update_session_reply_checker replies (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending_replies)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic t_update_cmd make_cmd(input logic [2:0] op);
        t_update_cmd c;
        c.op              = op;
        c.payload_short   = 1'b0;
        c.block_truncated = 1'b0;
        c.ver_major       = 8'($urandom);
        c.ver_minor       = 8'($urandom);
        c.ver_patch       = 8'($urandom);
        c.size_value      = $urandom;
        c.block_offset    = $urandom;
        c.block_length    = 16'($urandom);
        c.blk_tmo         = 16'($urandom);
        c.inst_tmo        = 16'($urandom);
        return c;
    endfunction

    function automatic t_update_cmd random_cmd();
        t_update_cmd c;
        c = make_cmd(3'($urandom_range(7)));
        c.payload_short   = ($urandom_range(4) == 0);
        c.block_truncated = ($urandom_range(4) == 0);
        return c;
    endfunction

    // Leaves tvalid high after the beat is taken; an idle gap before the next beat or a drain lowers it.
    task automatic send_beat(input t_update_cmd c);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.op;
        s_axis_tdata  <= {6'b0, c.inst_tmo, c.blk_tmo, c.block_length,
                          c.block_offset, c.size_value, c.ver_patch, c.ver_minor,
                          c.ver_major, c.block_truncated, c.payload_short};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_counted++;
    endtask

    // Holds the sender back until every reply has come and the pipeline is empty.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic set_registers(input logic [31:0] free_bytes, input logic [31:0] packet,
                                 input logic [31:0] mtu);
        write_reg(ucc_pkg::CFG_FREE_FLASH, free_bytes);
        write_reg(ucc_pkg::CFG_MAX_PACKET, packet);
        write_reg(ucc_pkg::CFG_MTU, mtu);
        // The unused index must leave every register alone.
        write_reg(CFG_UNUSED_INDEX, $urandom);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic run_directed();
        t_update_cmd c;
        send_beat(make_cmd(ucc_pkg::OP_QUERY_VER));
        send_beat(make_cmd(ucc_pkg::OP_HEADER));
        c = make_cmd(ucc_pkg::OP_DATA);
        c.block_offset = '0;
        send_beat(c);
        c = make_cmd(ucc_pkg::OP_COMPLETE);
        c.size_value = '0;
        send_beat(c);
        send_beat(make_cmd(ucc_pkg::OP_INSTALL));
        c = make_cmd(ucc_pkg::OP_ACTIVATE);
        c.payload_short = 1'b1;
        send_beat(c);
        send_beat(make_cmd(ucc_pkg::OP_OTHER));
        c = make_cmd(ucc_pkg::OP_HANDSHAKE);
        c.payload_short = 1'b1;
        send_beat(c);
        c = make_cmd(ucc_pkg::OP_HANDSHAKE);
        c.ver_major  = 8'hFF;
        c.ver_minor  = 8'hFF;
        c.ver_patch  = 8'hFF;
        c.size_value = '0;
        c.blk_tmo    = 16'hFFFF;
        c.inst_tmo   = 16'hFFFF;
        send_beat(c);
        c = make_cmd(ucc_pkg::OP_DATA);
        c.block_offset = '0;
        c.block_length = '0;
        send_beat(c);
        send_beat(make_cmd(ucc_pkg::OP_HEADER));
        c = make_cmd(ucc_pkg::OP_COMPLETE);
        c.size_value    = '0;
        c.payload_short = 1'b1;
        send_beat(c);
        c.payload_short = 1'b0;
        send_beat(c);
        send_beat(make_cmd(ucc_pkg::OP_INSTALL));
        send_beat(make_cmd(ucc_pkg::OP_INSTALL));
        c = make_cmd(ucc_pkg::OP_QUERY_VER);
        c.payload_short = 1'b1;
        send_beat(c);
        c = make_cmd(ucc_pkg::OP_HANDSHAKE);
        c.ver_major  = '0;
        c.ver_minor  = '0;
        c.ver_patch  = '0;
        c.size_value = 32'hFFFF_FFFF;
        c.blk_tmo    = '0;
        c.inst_tmo   = '0;
        send_beat(c);
        send_beat(make_cmd(ucc_pkg::OP_HEADER));
        c = make_cmd(ucc_pkg::OP_DATA);
        c.block_offset    = '0;
        c.block_length    = 16'hFFFF;
        c.block_truncated = 1'b1;
        send_beat(c);
        c.block_truncated = 1'b0;
        c.payload_short   = 1'b1;
        send_beat(c);
        c.payload_short = 1'b0;
        send_beat(c);
        // Same offset again is now out of order.
        send_beat(c);
        c.block_offset = 32'h0000_FFFF;
        send_beat(c);
        c = make_cmd(ucc_pkg::OP_COMPLETE);
        c.size_value = 32'hFFFF_FFFF;
        send_beat(c);
        send_beat(make_cmd(ucc_pkg::OP_INSTALL));
        c = make_cmd(ucc_pkg::OP_HANDSHAKE);
        c.size_value = 32'd10;
        send_beat(c);
        send_beat(make_cmd(ucc_pkg::OP_HEADER));
        c = make_cmd(ucc_pkg::OP_DATA);
        c.block_offset = '0;
        c.block_length = 16'd11;
        send_beat(c);
    endtask

    // One update from handshake to an optional install, with faults mixed into the block stream.
    task automatic run_session();
        t_update_cmd c;
        logic [31:0] image_len;
        logic [31:0] sent_len;
        logic [31:0] room;
        int          blocks;
        c = make_cmd(ucc_pkg::OP_HANDSHAKE);
        case ($urandom_range(9))
            0:       c.size_value = '0;
            1:       c.size_value = $urandom_range(70000, 200000);
            2:       c.size_value = $urandom;
            default: c.size_value = $urandom_range(1, 3000);
        endcase
        image_len = c.size_value;
        send_beat(c);
        if ($urandom_range(19) != 0) send_beat(make_cmd(ucc_pkg::OP_HEADER));
        sent_len = '0;
        blocks   = 0;
        while (sent_len != image_len && blocks < 16) begin
            room = image_len - sent_len;
            c = make_cmd(ucc_pkg::OP_DATA);
            c.block_offset = sent_len;
            if (room > 32'd65535)
                c.block_length = $urandom_range(1) ? 16'hFFFF : 16'($urandom);
            else
                c.block_length = ($urandom_range(2) == 0) ? 16'(room) : 16'($urandom_range(room));
            case ($urandom_range(11))
                0: c.block_truncated = 1'b1;
                1: c.block_offset = sent_len ^ (32'd1 << $urandom_range(31));
                2: c.payload_short = 1'b1;
                3: begin
                    if (room < 32'd65535)
                        c.block_length = 16'($urandom_range(65535, room + 32'd1));
                    else c.block_truncated = 1'b1;
                end
                4: c = random_cmd();
                default: sent_len = sent_len + {16'd0, c.block_length};
            endcase
            send_beat(c);
            blocks++;
        end
        c = make_cmd(ucc_pkg::OP_COMPLETE);
        c.size_value    = ($urandom_range(11) == 0) ? image_len + 32'd1 : image_len;
        c.payload_short = ($urandom_range(19) == 0);
        send_beat(c);
        // A header after completion withdraws it.
        if ($urandom_range(9) == 0) send_beat(make_cmd(ucc_pkg::OP_HEADER));
        if ($urandom_range(7) != 0) send_beat(make_cmd(ucc_pkg::OP_INSTALL));
        if ($urandom_range(3) == 0) send_beat(make_cmd(ucc_pkg::OP_INSTALL));
        send_beat(make_cmd($urandom_range(1) ? ucc_pkg::OP_ACTIVATE : ucc_pkg::OP_QUERY_VER));
    endtask

    task automatic run_random(input int goal);
        while (items_counted < goal) begin
            if ($urandom_range(3) == 0) send_beat(random_cmd());
            else run_session();
            if ($urandom_range(59) == 0) wait_idle();
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 6;
        recv_idle_pct = 77;
        run_directed();
        wait_idle();
        set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(ITEM_GOAL / 4);
        wait_idle();

        send_idle_pct = 77;
        recv_idle_pct = 6;
        set_registers('0, '0, '0);
        run_random(ITEM_GOAL / 2);
        wait_idle();
        set_registers($urandom, $urandom, $urandom);
        run_random(ITEM_GOAL * 3 / 4);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_registers(ucc_pkg::FREE_FLASH_RESET, {16'hA5A5, ucc_pkg::MAX_PACKET_RESET},
                      {16'h5A5A, ucc_pkg::MTU_RESET});
        run_random(ITEM_GOAL);
        wait_idle();

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
